### rtl/set_assoc_cache_lru_sim_macros.svh
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_SIM_MACROS_SVH

// same-cycle implication
`define SACL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SACL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// constants and codes of the tag-only lru cache model
// ----------------------------------------------------------------------------
package sacl_pkg;

   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;
   localparam int ADDR_WIDTH_DEF   = 64;

   localparam int CSR_DATA_W  = 6;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS        = 2'd2;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_STORE  = 2'd1;
   localparam logic [1:0] OP_MODIFY = 2'd2;
   localparam logic [1:0] OP_IFETCH = 2'd3;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_FILL  = 2'd1;
   localparam logic [1:0] OUT_EVICT = 2'd2;

   localparam int COUNT_W = 32;

endpackage

### rtl/set_assoc_cache_lru_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// tag-only set-associative cache with lru replacement, hit/miss counting
//
//   channel | direction | ports
//   --------+-----------+--------------------------------------------------
//   req     | in        | req_valid/req_ready, req_operation, req_address
//   rsp     | out       | rsp_valid/rsp_ready, rsp_outcome, rsp_last, totals
//   csr     | in        | csr_write_enable, csr_index, csr_write_data
//
// load/store: one lookup per request (set row read, then update and write back)
// modify: two lookups, each with a response; instruction fetch: no lookup, no response
// after reset a clearing pass over 2**MAX_SET_BITS set rows keeps req_ready low
// a response not yet taken holds the update of the following lookup
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim
   import sacl_pkg::*;
#(
   parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = MAX_WAYS_DEF,
   parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_operation,
   input  logic [ADDR_WIDTH-1:0]  req_address,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_outcome,
   output logic                   rsp_last,
   output logic [COUNT_W-1:0]     rsp_hits_total,
   output logic [COUNT_W-1:0]     rsp_misses_total,
   output logic [COUNT_W-1:0]     rsp_evictions_total,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SETW     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int RANKW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WIW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCW      = $clog2(MAX_WAYS + 1);
   localparam int LINEW    = ADDR_WIDTH + RANKW + 1;
   localparam int ROWW     = MAX_WAYS * LINEW;
   localparam logic [RANKW-1:0] RANK_MAX = RANKW'(MAX_WAYS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   state_type               state_ff;
   logic [SETW-1:0]         clr_cnt_ff;
   logic [1:0]              op_ff;
   logic [ADDR_WIDTH-1:0]   addr_ff;
   logic                    second_ff;
   logic [2:0]              set_bits_ff;
   logic [5:0]              offset_bits_ff;
   logic [3:0]              ways_ff;
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_outcome_ff;
   logic                    rsp_last_ff;
   logic [COUNT_W-1:0]      hits_ff;
   logic [COUNT_W-1:0]      misses_ff;
   logic [COUNT_W-1:0]      evictions_ff;

   logic [2:0]              s_eff;
   logic [WCW-1:0]          ways_eff;
   logic [6:0]              tag_shift;
   logic [ADDR_WIDTH-1:0]   tag;
   logic [ADDR_WIDTH-1:0]   addr_shifted;
   logic [SETW-1:0]         set_field_mask;
   logic [SETW-1:0]         set_idx;

   logic [ROWW-1:0]         rd_row;
   logic [ROWW-1:0]         new_row;
   logic                    ram_we;
   logic [SETW-1:0]         ram_waddr;
   logic [ROWW-1:0]         ram_wdata;

   logic [MAX_WAYS-1:0]     way_valid;
   logic [RANKW-1:0]        way_rank [MAX_WAYS];
   logic [ADDR_WIDTH-1:0]   way_tag [MAX_WAYS];
   logic [MAX_WAYS-1:0]     in_use;
   logic [MAX_WAYS-1:0]     hit_vec;
   logic [MAX_WAYS-1:0]     free_vec;
   logic                    hit_any;
   logic                    free_any;
   logic [WIW-1:0]          hit_way;
   logic [WIW-1:0]          free_way;
   logic [WIW-1:0]          victim;
   logic [WIW-1:0]          target;
   logic                    was_valid;
   logic [RANKW-1:0]        old_rank;
   logic [1:0]              outcome;

   logic                    out_free;
   logic                    exec_fire;
   logic                    last_lookup;
   logic                    finishing;

   // address split
   always_comb begin
      s_eff          = (int'(set_bits_ff) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_ff;
      ways_eff       = (ways_ff == 4'd0) ? WCW'(1)
                     : (int'(ways_ff) > MAX_WAYS) ? WCW'(MAX_WAYS) : WCW'(ways_ff);
      tag_shift      = 7'(offset_bits_ff) + 7'(s_eff);
      tag            = addr_ff & ({ADDR_WIDTH{1'b1}} << tag_shift);
      addr_shifted   = addr_ff >> offset_bits_ff;
      set_field_mask = ~({SETW{1'b1}} << s_eff);
      set_idx        = addr_shifted[SETW-1:0] & set_field_mask;
   end

   // way lookup and lru update
   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         way_tag[i]   = rd_row[i*LINEW +: ADDR_WIDTH];
         way_rank[i]  = rd_row[i*LINEW + ADDR_WIDTH +: RANKW];
         way_valid[i] = rd_row[i*LINEW + ADDR_WIDTH + RANKW];
         in_use[i]    = WCW'(i) < ways_eff;
         hit_vec[i]   = in_use[i] && way_valid[i] && (way_tag[i] == tag);
         free_vec[i]  = in_use[i] && !way_valid[i];
      end
      hit_any  = |hit_vec;
      free_any = |free_vec;
      hit_way  = '0;
      free_way = '0;
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_way = WIW'(i);
         end
         if (free_vec[i]) begin
            free_way = WIW'(i);
         end
      end
      victim = '0;
      for (int i = 1; i < MAX_WAYS; i++) begin
         if (in_use[i] && (way_rank[victim] < way_rank[i])) begin
            victim = WIW'(i);
         end
      end
      target    = hit_any ? hit_way : (free_any ? free_way : victim);
      was_valid = hit_any || !free_any;
      old_rank  = way_rank[target];
      outcome   = hit_any ? OUT_HIT : (free_any ? OUT_FILL : OUT_EVICT);
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WIW'(i) == target) begin
            new_row[i*LINEW +: LINEW] = {1'b1, {RANKW{1'b0}}, tag};
         end else if (in_use[i] && way_valid[i] && (!was_valid || way_rank[i] < old_rank)
                      && (way_rank[i] < RANK_MAX)) begin
            new_row[i*LINEW +: LINEW] = {1'b1, way_rank[i] + RANKW'(1), way_tag[i]};
         end else begin
            new_row[i*LINEW +: LINEW] = {way_valid[i], way_rank[i], way_tag[i]};
         end
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign exec_fire   = (state_ff == ST_EXEC) && out_free;
   assign last_lookup = !((op_ff == OP_MODIFY) && !second_ff);
   assign finishing   = exec_fire && last_lookup;
   assign req_ready   = (state_ff == ST_IDLE) || finishing;

   assign ram_we    = exec_fire || (state_ff == ST_CLEAR);
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : set_idx;
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : new_row;

   sacl_ram #(
      .WIDTH (ROWW),
      .DEPTH (NUM_SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (state_ff == ST_READ),
      .rd_addr (set_idx),
      .rd_data (rd_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_cnt_ff     <= '0;
         second_ff      <= 1'b0;
         set_bits_ff    <= '0;
         offset_bits_ff <= '0;
         ways_ff        <= 4'd1;
         rsp_valid_ff   <= 1'b0;
         hits_ff        <= '0;
         misses_ff      <= '0;
         evictions_ff   <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_SET_BITS:    set_bits_ff    <= csr_write_data[2:0];
               CSR_OFFSET_BITS: offset_bits_ff <= csr_write_data[5:0];
               CSR_WAYS:        ways_ff        <= csr_write_data[3:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && !exec_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (clr_cnt_ff == SETW'(NUM_SETS - 1)) begin
                  state_ff <= ST_IDLE;
               end else begin
                  clr_cnt_ff <= clr_cnt_ff + SETW'(1);
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_operation;
                  addr_ff   <= req_address;
                  second_ff <= 1'b0;
                  state_ff  <= (req_operation == OP_IFETCH) ? ST_IDLE : ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_outcome_ff <= outcome;
                  rsp_last_ff    <= last_lookup;
                  if (hit_any) begin
                     hits_ff <= hits_ff + COUNT_W'(1);
                  end else begin
                     misses_ff <= misses_ff + COUNT_W'(1);
                  end
                  if (!hit_any && !free_any) begin
                     evictions_ff <= evictions_ff + COUNT_W'(1);
                  end
                  if (!last_lookup) begin
                     second_ff <= 1'b1;
                     state_ff  <= ST_READ;
                  end else if (req_valid) begin
                     op_ff     <= req_operation;
                     addr_ff   <= req_address;
                     second_ff <= 1'b0;
                     state_ff  <= (req_operation == OP_IFETCH) ? ST_IDLE : ST_READ;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = rsp_outcome_ff;
   assign rsp_last            = rsp_last_ff;
   assign rsp_hits_total      = hits_ff;
   assign rsp_misses_total    = misses_ff;
   assign rsp_evictions_total = evictions_ff;

endmodule

### rtl/sacl_ram.sv
// ----------------------------------------------------------------------------
// sacl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/sacl_checker.sv
// ----------------------------------------------------------------------------
// sacl_checker
// port-level checks of the lru cache model, bound to the top level
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_sim_macros.svh"

module sacl_checker
   import sacl_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [1:0]         rsp_outcome,
   input logic [COUNT_W-1:0] rsp_hits_total,
   input logic [COUNT_W-1:0] rsp_misses_total,
   input logic [COUNT_W-1:0] rsp_evictions_total
);

   logic [COUNT_W-1:0] prev_hits_ff;
   logic [COUNT_W-1:0] prev_misses_ff;
   logic [COUNT_W-1:0] prev_evictions_ff;

   // totals seen with the last taken response
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_hits_ff      <= '0;
         prev_misses_ff    <= '0;
         prev_evictions_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         prev_hits_ff      <= rsp_hits_total;
         prev_misses_ff    <= rsp_misses_total;
         prev_evictions_ff <= rsp_evictions_total;
      end
   end

   `SACL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_outcome) && $stable(rsp_hits_total),
      "response changed while stalled")

   `SACL_ASSERT_IMP(a_hits_step, clock, reset, rsp_valid,
      rsp_hits_total == prev_hits_ff + COUNT_W'(rsp_outcome == OUT_HIT),
      "hit total does not match outcome")

   `SACL_ASSERT_IMP(a_misses_step, clock, reset, rsp_valid,
      rsp_misses_total == prev_misses_ff + COUNT_W'(rsp_outcome != OUT_HIT),
      "miss total does not match outcome")

   `SACL_ASSERT_IMP(a_evict_step, clock, reset, rsp_valid,
      rsp_evictions_total == prev_evictions_ff + COUNT_W'(rsp_outcome == OUT_EVICT),
      "eviction total does not match outcome")

   `SACL_ASSERT_IMP(a_clear_after_reset, clock, reset, $past(reset),
      !req_ready,
      "request taken during clearing pass")

endmodule

bind set_assoc_cache_lru_sim sacl_checker u_sacl_checker (.*);

### tb/set_assoc_cache_lru_sim_test.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim_test
// self-checking testbench of the tag-only lru cache model
//
// a queue-fed driver offers memory requests with random gaps while a monitor
// takes responses with random stalls. every accepted request runs through a
// local copy of the cache (valid bits, tags, age ranks and hit/miss/eviction
// counters) and the predicted lookups are compared with the responses in
// order. the cache geometry is reprogrammed between phases, including
// out-of-range set/way settings, index bits reaching past the address, and
// way counts shrunk and grown while lines are valid. one phase holds the
// response side off for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_sim_test
   import sacl_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SETS       = 1 << MAX_SET_BITS_DEF;
   localparam int NUM_LINES      = NUM_SETS * MAX_WAYS_DEF;
   localparam int NUM_PHASES     = 12;
   localparam int PHASE_ITEMS    = 112;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [63:0] addr;
   } access_type;

   typedef struct {
      logic [1:0]         outcome;
      logic               last;
      logic [COUNT_W-1:0] hits;
      logic [COUNT_W-1:0] misses;
      logic [COUNT_W-1:0] evictions;
   } lookup_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_operation = OP_LOAD;
   logic [63:0]            req_address = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_outcome;
   logic                   rsp_last;
   logic [COUNT_W-1:0]     rsp_hits_total;
   logic [COUNT_W-1:0]     rsp_misses_total;
   logic [COUNT_W-1:0]     rsp_evictions_total;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SET_BITS;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   set_assoc_cache_lru_sim dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_address         (req_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_outcome         (rsp_outcome),
      .rsp_last            (rsp_last),
      .rsp_hits_total      (rsp_hits_total),
      .rsp_misses_total    (rsp_misses_total),
      .rsp_evictions_total (rsp_evictions_total),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #5 clock = ~clock;

   // local cache copy
   logic               line_valid [NUM_LINES];
   logic [63:0]        line_tag   [NUM_LINES];
   logic [2:0]         line_rank  [NUM_LINES];
   logic [COUNT_W-1:0] hit_count;
   logic [COUNT_W-1:0] miss_count;
   logic [COUNT_W-1:0] evict_count;
   int unsigned        cfg_set_bits;
   int unsigned        cfg_offset_bits;
   int unsigned        cfg_ways;

   access_type        pending_requests [$];
   lookup_result_type expected_lookups [$];

   int   error_count = 0;
   logic req_idle_on = 1'b1;
   logic rsp_idle_on = 1'b1;
   logic long_hold_go = 1'b0;
   logic long_hold_done = 1'b0;
   int   req_gap = 0;
   int   rsp_stall = 0;
   int   hold_left = 0;
   int   quiet_cycles = 0;

   function automatic logic [63:0] ones_from(int unsigned n);
      return (n >= 64) ? 64'd0 : ({64{1'b1}} << n);
   endfunction

   function automatic int unsigned used_set_bits();
      return (cfg_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : cfg_set_bits;
   endfunction

   function automatic int unsigned used_ways();
      if (cfg_ways == 0)
         return 1;
      return (cfg_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : cfg_ways;
   endfunction

   function automatic void clear_cache();
      for (int i = 0; i < NUM_LINES; i++) begin
         line_valid[i] = 1'b0;
         line_tag[i]   = '0;
         line_rank[i]  = '0;
      end
      hit_count       = '0;
      miss_count      = '0;
      evict_count     = '0;
      cfg_set_bits    = 0;
      cfg_offset_bits = 0;
      cfg_ways        = 1;
   endfunction

   // make one way most recent, aging the lines that were younger than it
   function automatic void make_recent(int unsigned base, int unsigned nways,
                                       int unsigned way, logic was_valid);
      int unsigned r;
      r = was_valid ? int'(line_rank[base + way]) : 255;
      for (int unsigned i = 0; i < nways; i++) begin
         if (i != way && line_valid[base + i] && line_rank[base + i] < r &&
             line_rank[base + i] < MAX_WAYS_DEF - 1)
            line_rank[base + i] = line_rank[base + i] + 3'd1;
      end
      line_valid[base + way] = 1'b1;
      line_rank[base + way]  = '0;
   endfunction

   function automatic logic [1:0] cache_lookup(logic [63:0] addr);
      int unsigned sb;
      int unsigned nways;
      int unsigned set_no;
      int unsigned base;
      int unsigned victim;
      logic [63:0] tmask;
      logic [63:0] smask;
      logic [63:0] tag_val;
      sb      = used_set_bits();
      nways   = used_ways();
      tmask   = ones_from(cfg_offset_bits + sb);
      smask   = ones_from(cfg_offset_bits) ^ tmask;
      tag_val = addr & tmask;
      set_no  = (cfg_offset_bits >= 64) ? 0 :
                int'(((addr & smask) >> cfg_offset_bits) & 64'(NUM_SETS - 1));
      base    = set_no * MAX_WAYS_DEF;
      for (int unsigned i = 0; i < nways; i++) begin
         if (line_valid[base + i] && line_tag[base + i] == tag_val) begin
            hit_count = hit_count + 1;
            make_recent(base, nways, i, 1'b1);
            return OUT_HIT;
         end
      end
      miss_count = miss_count + 1;
      for (int unsigned i = 0; i < nways; i++) begin
         if (!line_valid[base + i]) begin
            line_tag[base + i] = tag_val;
            make_recent(base, nways, i, 1'b0);
            return OUT_FILL;
         end
      end
      evict_count = evict_count + 1;
      victim = 0;
      for (int unsigned i = 1; i < nways; i++) begin
         if (line_rank[base + victim] < line_rank[base + i])
            victim = i;
      end
      line_tag[base + victim] = tag_val;
      make_recent(base, nways, victim, 1'b1);
      return OUT_EVICT;
   endfunction

   function automatic void push_lookup(logic [63:0] addr, logic last);
      lookup_result_type r;
      r.outcome   = cache_lookup(addr);
      r.last      = last;
      r.hits      = hit_count;
      r.misses    = miss_count;
      r.evictions = evict_count;
      expected_lookups.push_back(r);
   endfunction

   function automatic void predict_access(logic [1:0] op, logic [63:0] addr);
      if (op == OP_IFETCH)
         return;
      if (op == OP_MODIFY)
         push_lookup(addr, 1'b0);
      push_lookup(addr, 1'b1);
   endfunction

   // request driver
   always @(posedge clock) begin
      logic       offering;
      access_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            predict_access(req_operation, req_address);
            offering = 1'b0;
         end
         if (!offering) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_requests.size() > 0) begin
               nxt = pending_requests.pop_front();
               req_operation <= nxt.op;
               req_address   <= nxt.addr;
               offering = 1'b1;
               req_gap = req_idle_on ? $urandom_range(0, 4) : 0;
            end
         end
         req_valid <= offering;
      end
   end

   task automatic check_field(string name, logic [COUNT_W-1:0] want,
                              logic [COUNT_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   // response monitor
   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               $error("response with no request outstanding: outcome %0d", rsp_outcome);
               error_count++;
            end else begin
               want = expected_lookups.pop_front();
               check_field("outcome", want.outcome, rsp_outcome);
               check_field("last", want.last, rsp_last);
               check_field("hits_total", want.hits, rsp_hits_total);
               check_field("misses_total", want.misses, rsp_misses_total);
               check_field("evictions_total", want.evictions, rsp_evictions_total);
            end
            rsp_stall = rsp_idle_on ? $urandom_range(0, 4) : 0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         if (long_hold_go && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left = LONG_HOLD;
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_ready <= (rsp_stall == 0 && hold_left == 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_SET_BITS:    cfg_set_bits    = data[2:0];
         CSR_OFFSET_BITS: cfg_offset_bits = data;
         CSR_WAYS:        cfg_ways        = data[3:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_lookups.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void add_request(logic [1:0] op, logic [63:0] addr);
      access_type a;
      a.op   = op;
      a.addr = addr;
      pending_requests.push_back(a);
   endfunction

   // mostly addresses from a small tag/set pool so that hits and evictions occur
   function automatic void fill_phase(int count, logic [63:0] tag_base);
      int unsigned sb;
      int unsigned pick;
      logic [1:0]  op;
      logic [63:0] addr;
      logic [63:0] tag_part;
      logic [63:0] set_part;
      sb = used_set_bits();
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 9);
         if (pick < 4)
            op = OP_LOAD;
         else if (pick < 7)
            op = OP_STORE;
         else if (pick < 9)
            op = OP_MODIFY;
         else
            op = OP_IFETCH;
         if ($urandom_range(0, 9) == 0) begin
            addr = {$urandom, $urandom};
         end else begin
            tag_part = (tag_base + 64'($urandom_range(0, used_ways() + 1)))
                       << (cfg_offset_bits + sb);
            set_part = (64'($urandom_range(0, 3)) << cfg_offset_bits) &
                       (ones_from(cfg_offset_bits) ^ ones_from(cfg_offset_bits + sb));
            addr = tag_part | set_part | ({$urandom, $urandom} & ~ones_from(cfg_offset_bits));
         end
         add_request(op, addr);
      end
   endfunction

   int unsigned phase_set_bits [NUM_PHASES] = '{2, 6, 0, 7, 3, 6, 1, 4, 4, 5, 6, 2};
   int unsigned phase_offset   [NUM_PHASES] = '{4, 6, 0, 5, 63, 58, 3, 32, 32, 1, 0, 12};
   int unsigned phase_ways     [NUM_PHASES] = '{2, 8, 1, 15, 4, 3, 0, 8, 2, 8, 5, 4};

   initial begin
      clear_cache();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);

      // directed: one set, one way, every address its own tag
      add_request(OP_IFETCH, 64'd0);
      add_request(OP_LOAD,   64'd0);
      add_request(OP_LOAD,   64'd0);
      add_request(OP_STORE,  {64{1'b1}});
      add_request(OP_MODIFY, {64{1'b1}});
      add_request(OP_MODIFY, 64'h5555_5555_5555_5555);
      add_request(OP_LOAD,   64'hAAAA_AAAA_AAAA_AAAA);
      add_request(OP_IFETCH, {64{1'b1}});
      add_request(OP_STORE,  64'hAAAA_AAAA_AAAA_AAAA);
      add_request(OP_LOAD,   64'h8000_0000_0000_0000);
      add_request(OP_MODIFY, 64'd1);
      add_request(OP_LOAD,   64'd0);
      wait_drained();

      // directed: ignored register index, then two ways in four sets
      write_csr(CSR_UNUSED, 6'h3F);
      write_csr(CSR_SET_BITS, 6'd2);
      write_csr(CSR_WAYS, 6'd2);
      add_request(OP_LOAD,   64'h00);
      add_request(OP_LOAD,   64'h04);
      add_request(OP_LOAD,   64'h08);
      add_request(OP_LOAD,   64'h00);
      add_request(OP_STORE,  64'h10);
      add_request(OP_LOAD,   64'h04);
      add_request(OP_MODIFY, 64'h14);
      add_request(OP_LOAD,   64'h00);
      add_request(OP_IFETCH, 64'h00);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_csr(CSR_SET_BITS, {3'($urandom), 3'(phase_set_bits[p])});
         write_csr(CSR_OFFSET_BITS, 6'(phase_offset[p]));
         write_csr(CSR_WAYS, {2'($urandom), 4'(phase_ways[p])});
         if (p == 4)
            write_csr(CSR_UNUSED, 6'($urandom));
         req_idle_on <= (p % 3 != 0) && (p != 1);
         rsp_idle_on <= (p % 4 != 2);
         if (p == 1)
            long_hold_go <= 1'b1;
         fill_phase(PHASE_ITEMS, {$urandom, $urandom});
         wait_drained();
      end

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
